>>> rtl/hfvr_pkg.sv
// ============================================================================
// hfvr_pkg
// Shared widths, constants and pipeline payload types for the heading-frame
// velocity rotation block.
// ============================================================================
package hfvr_pkg;

    localparam int Q_W           = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int PIPE_DEPTH    = CORDIC_STAGES + 5;

    // Pipeline stage positions in the valid chain.
    localparam int S_PROD  = 0;
    localparam int S_AB    = 1;
    localparam int S_PRE   = 2;
    localparam int S_CORD0 = 3;
    localparam int S_MUL   = CORDIC_STAGES + 3;
    localparam int S_OUT   = CORDIC_STAGES + 4;

    localparam int SQ_W       = 2 * Q_W;
    localparam int AB_W       = 36;
    localparam int EXTRA_FRAC = 12;
    localparam int PV_W       = 31;
    localparam int PROD_W     = 2 * PV_W;
    localparam int GAIN_FRAC  = 30;
    localparam int RND_SHIFT  = GAIN_FRAC + EXTRA_FRAC;
    localparam int RES_W      = PROD_W - RND_SHIFT;

    localparam logic signed [PV_W-1:0]   INV_GAIN = PV_W'(652032874);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (RND_SHIFT - 1);
    localparam logic signed [Q_W-1:0]    Q_MAX    = 16'sh7FFF;
    localparam logic signed [Q_W-1:0]    Q_MIN    = 16'sh8000;

    typedef struct packed {
        logic                  bad;
        logic                  byp;
        logic signed [Q_W-1:0] vx;
        logic signed [Q_W-1:0] vy;
        logic signed [Q_W-1:0] vz;
        logic signed [Q_W-1:0] yr;
    } side_t;

    typedef struct packed {
        logic signed [SQ_W-1:0] ww;
        logic signed [SQ_W-1:0] xx;
        logic signed [SQ_W-1:0] yy;
        logic signed [SQ_W-1:0] zz;
        logic signed [SQ_W-1:0] wz;
        logic signed [SQ_W-1:0] xy;
        side_t                  side;
    } prod_t;

    typedef struct packed {
        logic signed [AB_W-1:0] a;
        logic signed [AB_W-1:0] b;
        side_t                  side;
    } ab_t;

    typedef struct packed {
        logic signed [AB_W-1:0] a;
        logic signed [AB_W-1:0] b;
        logic signed [PV_W-1:0] px;
        logic signed [PV_W-1:0] py;
        side_t                  side;
    } cord_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] prx;
        logic signed [PROD_W-1:0] pry;
        side_t                    side;
    } mul_t;

    typedef struct packed {
        logic                  bad_attitude;
        logic signed [Q_W-1:0] world_vx;
        logic signed [Q_W-1:0] world_vy;
        logic signed [Q_W-1:0] world_vz;
        logic signed [Q_W-1:0] yaw_rate_out;
    } res_t;

    // Clamp a rounded result to the signed 16-bit range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [RES_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[RES_W-1:Q_W-1] == {(RES_W-Q_W+1){v[RES_W-1]}}) begin
            r = v[Q_W-1:0];
        end
        else if (v[RES_W-1]) begin
            r = Q_MIN;
        end
        else begin
            r = Q_MAX;
        end
        return r;
    endfunction

endpackage

>>> rtl/hfvr_in_if.sv
// ============================================================================
// hfvr_in_if
// Command channel: attitude quaternion and heading-frame velocity beat.
// ============================================================================
interface hfvr_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [hfvr_pkg::Q_W-1:0] quat_w;
    logic signed [hfvr_pkg::Q_W-1:0] quat_x;
    logic signed [hfvr_pkg::Q_W-1:0] quat_y;
    logic signed [hfvr_pkg::Q_W-1:0] quat_z;
    logic signed [hfvr_pkg::Q_W-1:0] heading_vx;
    logic signed [hfvr_pkg::Q_W-1:0] heading_vy;
    logic signed [hfvr_pkg::Q_W-1:0] heading_vz;
    logic signed [hfvr_pkg::Q_W-1:0] yaw_rate_in;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z,
               heading_vx, heading_vy, heading_vz, yaw_rate_in,
        input  ready
    );

    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z,
               heading_vx, heading_vy, heading_vz, yaw_rate_in,
        output ready
    );
endinterface

>>> rtl/hfvr_out_if.sv
// ============================================================================
// hfvr_out_if
// Result channel: world-frame velocity beat and attitude error flag.
// ============================================================================
interface hfvr_out_if;
    logic                            valid;
    logic                            ready;
    logic                            bad_attitude;
    logic signed [hfvr_pkg::Q_W-1:0] world_vx;
    logic signed [hfvr_pkg::Q_W-1:0] world_vy;
    logic signed [hfvr_pkg::Q_W-1:0] world_vz;
    logic signed [hfvr_pkg::Q_W-1:0] yaw_rate_out;

    modport source (
        output valid, bad_attitude, world_vx, world_vy, world_vz, yaw_rate_out,
        input  ready
    );

    modport sink (
        input  valid, bad_attitude, world_vx, world_vy, world_vz, yaw_rate_out,
        output ready
    );
endinterface

>>> rtl/heading_frame_velocity_rotate_top.sv
// ============================================================================
// heading_frame_velocity_rotate_top
// Rotates a heading-frame velocity command about Z by the yaw of an attitude
// quaternion, using a fully pipelined CORDIC (vectoring drives rotation).
// ============================================================================
// Throughput: one beat per cycle while the output is not stalled; every stage
// is a register with its own valid. A stage loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out and a stalled output holds
// only the stages behind it. Reset (rst_n low, asynchronous) clears the valid
// bits; data is not reset.
module heading_frame_velocity_rotate_top (
    input  logic       clk,
    input  logic       rst_n,
    hfvr_in_if.sink    cmd,
    hfvr_out_if.source vel
);

    localparam int C = hfvr_pkg::CORDIC_STAGES;
    localparam int D = hfvr_pkg::PIPE_DEPTH;

    logic [D-1:0] vld_reg;
    logic [D-1:0] vld_next;
    logic [D-1:0] move;

    hfvr_pkg::prod_t prod_reg;
    hfvr_pkg::prod_t prod_next;
    hfvr_pkg::ab_t   ab_reg;
    hfvr_pkg::ab_t   ab_next;
    hfvr_pkg::cord_t cord_reg  [0:C];
    hfvr_pkg::cord_t cord_next [0:C];
    hfvr_pkg::mul_t  mul_reg;
    hfvr_pkg::mul_t  mul_next;
    hfvr_pkg::res_t  res_reg;
    hfvr_pkg::res_t  res_next;

    // ------------------------------------------------------------------
    // Valid chain and backpressure
    // ------------------------------------------------------------------
    assign move[D-1] = !vld_reg[D-1] || vel.ready;

    genvar gk;
    generate
        for (gk = 0; gk < D - 1; gk++) begin : g_move
            assign move[gk] = !vld_reg[gk] || move[gk+1];
        end
    endgenerate

    assign vld_next = {vld_reg[D-2:0], cmd.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_reg & ~move) | (vld_next & move);
        end
    end

    assign cmd.ready = move[hfvr_pkg::S_PROD];

    // ------------------------------------------------------------------
    // Stage: quaternion products
    // ------------------------------------------------------------------
    always_comb
    begin
        prod_next.ww      = cmd.quat_w * cmd.quat_w;
        prod_next.xx      = cmd.quat_x * cmd.quat_x;
        prod_next.yy      = cmd.quat_y * cmd.quat_y;
        prod_next.zz      = cmd.quat_z * cmd.quat_z;
        prod_next.wz      = cmd.quat_w * cmd.quat_z;
        prod_next.xy      = cmd.quat_x * cmd.quat_y;
        prod_next.side.bad = (cmd.quat_w == '0) && (cmd.quat_x == '0) &&
                             (cmd.quat_y == '0) && (cmd.quat_z == '0);
        prod_next.side.byp = 1'b0;
        prod_next.side.vx  = cmd.heading_vx;
        prod_next.side.vy  = cmd.heading_vy;
        prod_next.side.vz  = cmd.heading_vz;
        prod_next.side.yr  = cmd.yaw_rate_in;
    end

    always_ff @(posedge clk)
    begin
        if (move[hfvr_pkg::S_PROD])
        begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage: yaw vector a = w^2 + x^2 - y^2 - z^2, b = 2(wz + xy)
    // ------------------------------------------------------------------
    always_comb
    begin
        ab_next.a    = hfvr_pkg::AB_W'(prod_reg.ww) + hfvr_pkg::AB_W'(prod_reg.xx)
                     - hfvr_pkg::AB_W'(prod_reg.yy) - hfvr_pkg::AB_W'(prod_reg.zz);
        ab_next.b    = (hfvr_pkg::AB_W'(prod_reg.wz) + hfvr_pkg::AB_W'(prod_reg.xy)) <<< 1;
        ab_next.side = prod_reg.side;
    end

    always_ff @(posedge clk)
    begin
        if (move[hfvr_pkg::S_AB])
        begin
            ab_reg <= ab_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage: quarter-turn prerotation into the right half plane
    // ------------------------------------------------------------------
    logic signed [hfvr_pkg::PV_W-1:0] pre_vx;
    logic signed [hfvr_pkg::PV_W-1:0] pre_vy;

    always_comb
    begin
        pre_vx = hfvr_pkg::PV_W'(ab_reg.side.vx) <<< hfvr_pkg::EXTRA_FRAC;
        pre_vy = hfvr_pkg::PV_W'(ab_reg.side.vy) <<< hfvr_pkg::EXTRA_FRAC;
        cord_next[0].side     = ab_reg.side;
        cord_next[0].side.byp = (ab_reg.b == '0) && !ab_reg.a[hfvr_pkg::AB_W-1];
        if (!ab_reg.a[hfvr_pkg::AB_W-1])
        begin
            cord_next[0].a  = ab_reg.a;
            cord_next[0].b  = ab_reg.b;
            cord_next[0].px = pre_vx;
            cord_next[0].py = pre_vy;
        end
        else if (!ab_reg.b[hfvr_pkg::AB_W-1])
        begin
            // Yaw in the second quadrant: turn the yaw vector by -90 degrees.
            cord_next[0].a  = ab_reg.b;
            cord_next[0].b  = -ab_reg.a;
            cord_next[0].px = -pre_vy;
            cord_next[0].py = pre_vx;
        end
        else
        begin
            cord_next[0].a  = -ab_reg.b;
            cord_next[0].b  = ab_reg.a;
            cord_next[0].px = pre_vy;
            cord_next[0].py = -pre_vx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[hfvr_pkg::S_PRE])
        begin
            cord_reg[0] <= cord_next[0];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC micro-rotation stages, one shift amount per stage
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < C; gi++) begin : g_cordic
            logic signed [hfvr_pkg::AB_W-1:0] da;
            logic signed [hfvr_pkg::AB_W-1:0] db;
            logic signed [hfvr_pkg::PV_W-1:0] dx;
            logic signed [hfvr_pkg::PV_W-1:0] dy;

            always_comb
            begin
                da = cord_reg[gi].a >>> gi;
                db = cord_reg[gi].b >>> gi;
                dx = cord_reg[gi].px >>> gi;
                dy = cord_reg[gi].py >>> gi;
                cord_next[gi+1].side = cord_reg[gi].side;
                if (!cord_reg[gi].b[hfvr_pkg::AB_W-1])
                begin
                    cord_next[gi+1].a  = cord_reg[gi].a + db;
                    cord_next[gi+1].b  = cord_reg[gi].b - da;
                    cord_next[gi+1].px = cord_reg[gi].px - dy;
                    cord_next[gi+1].py = cord_reg[gi].py + dx;
                end
                else
                begin
                    cord_next[gi+1].a  = cord_reg[gi].a - db;
                    cord_next[gi+1].b  = cord_reg[gi].b + da;
                    cord_next[gi+1].px = cord_reg[gi].px + dy;
                    cord_next[gi+1].py = cord_reg[gi].py - dx;
                end
            end

            always_ff @(posedge clk)
            begin
                if (move[hfvr_pkg::S_CORD0 + gi])
                begin
                    cord_reg[gi+1] <= cord_next[gi+1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage: CORDIC gain compensation
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_next.prx  = cord_reg[C].px * hfvr_pkg::INV_GAIN;
        mul_next.pry  = cord_reg[C].py * hfvr_pkg::INV_GAIN;
        mul_next.side = cord_reg[C].side;
    end

    always_ff @(posedge clk)
    begin
        if (move[hfvr_pkg::S_MUL])
        begin
            mul_reg <= mul_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage: round half up, saturate, select special cases
    // ------------------------------------------------------------------
    logic signed [hfvr_pkg::PROD_W-1:0] rnd_x;
    logic signed [hfvr_pkg::PROD_W-1:0] rnd_y;

    always_comb
    begin
        rnd_x = (mul_reg.prx + hfvr_pkg::RND_HALF) >>> hfvr_pkg::RND_SHIFT;
        rnd_y = (mul_reg.pry + hfvr_pkg::RND_HALF) >>> hfvr_pkg::RND_SHIFT;
        res_next.bad_attitude = mul_reg.side.bad;
        res_next.world_vz     = mul_reg.side.vz;
        res_next.yaw_rate_out = mul_reg.side.yr;
        if (mul_reg.side.byp)
        begin
            res_next.world_vx = mul_reg.side.vx;
            res_next.world_vy = mul_reg.side.vy;
        end
        else
        begin
            res_next.world_vx = hfvr_pkg::sat_q(rnd_x[hfvr_pkg::RES_W-1:0]);
            res_next.world_vy = hfvr_pkg::sat_q(rnd_y[hfvr_pkg::RES_W-1:0]);
        end
        // An all-zero quaternion zeroes every velocity field.
        if (mul_reg.side.bad)
        begin
            res_next.world_vx     = '0;
            res_next.world_vy     = '0;
            res_next.world_vz     = '0;
            res_next.yaw_rate_out = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[hfvr_pkg::S_OUT])
        begin
            res_reg <= res_next;
        end
    end

    assign vel.valid        = vld_reg[hfvr_pkg::S_OUT];
    assign vel.bad_attitude = res_reg.bad_attitude;
    assign vel.world_vx     = res_reg.world_vx;
    assign vel.world_vy     = res_reg.world_vy;
    assign vel.world_vz     = res_reg.world_vz;
    assign vel.yaw_rate_out = res_reg.yaw_rate_out;

endmodule

>>> rtl/hfvr_checker.sv
// ============================================================================
// hfvr_checker
// Port-level checks for the heading-frame velocity rotation block, bound to
// the top level.
// ============================================================================
module hfvr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cmd_valid,
    input logic                            cmd_ready,
    input logic                            vel_valid,
    input logic                            vel_ready,
    input logic                            bad_attitude,
    input logic signed [hfvr_pkg::Q_W-1:0] world_vx,
    input logic signed [hfvr_pkg::Q_W-1:0] world_vy,
    input logic signed [hfvr_pkg::Q_W-1:0] world_vz,
    input logic signed [hfvr_pkg::Q_W-1:0] yaw_rate_out
);

    localparam int CNT_W = $clog2(hfvr_pkg::PIPE_DEPTH + 1);

    logic             cmd_beat;
    logic             vel_beat;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign cmd_beat = cmd_valid && cmd_ready;
    assign vel_beat = vel_valid && vel_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd_beat && !vel_beat)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!cmd_beat && vel_beat)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Beats inside the block: accepted commands not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_bad_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        vel_valid && bad_attitude |->
            world_vx == '0 && world_vy == '0 && world_vz == '0 && yaw_rate_out == '0)
        else $error("bad attitude beat carries nonzero velocity");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        vel_valid && !vel_ready |=>
            vel_valid && $stable({bad_attitude, world_vx, world_vy, world_vz, yaw_rate_out}))
        else $error("stalled result beat changed");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        vel_valid |-> cnt_reg != '0)
        else $error("result beat without an outstanding command");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CNT_W'(hfvr_pkg::PIPE_DEPTH) && !vel_ready |-> !cmd_ready)
        else $error("full pipeline accepted a command while stalled");

endmodule

bind heading_frame_velocity_rotate_top hfvr_checker u_hfvr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .vel_valid    (vel.valid),
    .vel_ready    (vel.ready),
    .bad_attitude (vel.bad_attitude),
    .world_vx     (vel.world_vx),
    .world_vy     (vel.world_vy),
    .world_vz     (vel.world_vz),
    .yaw_rate_out (vel.yaw_rate_out)
);

>>> dv/world_velocity_checker.sv
// ============================================================================
// world_velocity_checker
// Watches the command and result channels of the heading-frame velocity
// rotation block. It predicts each world-frame result from the accepted
// command beat and compares every result beat, field by field, in order.
// ============================================================================
module world_velocity_checker (
    input  logic clk,
    input  logic rst_n,
    hfvr_in_if   cmd,
    hfvr_out_if  vel,
    output int   mismatches,
    output int   pending,
    output int   checked,
    output int   zero_attitude,
    output int   saturated
);

    localparam int     VEL_GUARD    = 12;
    localparam int     GAIN_SHIFT   = 30;
    localparam longint INV_GAIN_Q30 = 64'sd652032874;
    localparam longint ROUND_HALF   = 64'sd1 <<< (GAIN_SHIFT + VEL_GUARD - 1);

    hfvr_pkg::res_t expected_world_q[$];
    hfvr_pkg::res_t want;
    hfvr_pkg::res_t got;

    function automatic logic signed [hfvr_pkg::Q_W-1:0] clamp_q(input longint v);
        logic signed [hfvr_pkg::Q_W-1:0] r;
        if (v > 32767)
        begin
            r = hfvr_pkg::Q_MAX;
        end
        else if (v < -32768)
        begin
            r = hfvr_pkg::Q_MIN;
        end
        else
        begin
            r = hfvr_pkg::Q_W'(v);
        end
        return r;
    endfunction

    // The yaw vector (ya, yb) is driven onto +x while the velocity is turned
    // the other way, so the velocity ends up rotated by the attitude's yaw.
    function automatic hfvr_pkg::res_t rotate_to_world(
        input logic signed [hfvr_pkg::Q_W-1:0] w,
        input logic signed [hfvr_pkg::Q_W-1:0] x,
        input logic signed [hfvr_pkg::Q_W-1:0] y,
        input logic signed [hfvr_pkg::Q_W-1:0] z,
        input logic signed [hfvr_pkg::Q_W-1:0] vx,
        input logic signed [hfvr_pkg::Q_W-1:0] vy,
        input logic signed [hfvr_pkg::Q_W-1:0] vz,
        input logic signed [hfvr_pkg::Q_W-1:0] yr
    );
        longint         ya;
        longint         yb;
        longint         ux;
        longint         uy;
        longint         t;
        longint         da;
        longint         db;
        longint         dx;
        longint         dy;
        longint         rx;
        longint         ry;
        hfvr_pkg::res_t r;
        r = '0;
        if (w == 0 && x == 0 && y == 0 && z == 0)
        begin
            r.bad_attitude = 1'b1;
        end
        else
        begin
            ya = longint'(w) * longint'(w) + longint'(x) * longint'(x)
               - longint'(y) * longint'(y) - longint'(z) * longint'(z);
            yb = 2 * (longint'(w) * longint'(z) + longint'(x) * longint'(y));
            if (yb == 0 && ya >= 0)
            begin
                rx = longint'(vx);
                ry = longint'(vy);
            end
            else
            begin
                ux = longint'(vx) <<< VEL_GUARD;
                uy = longint'(vy) <<< VEL_GUARD;
                // Left half plane: an exact quarter turn first, so the
                // iterations only have to cover +/-90 degrees.
                if (ya < 0)
                begin
                    if (yb >= 0)
                    begin
                        t = ya; ya = yb; yb = -t;
                        t = ux; ux = -uy; uy = t;
                    end
                    else
                    begin
                        t = ya; ya = -yb; yb = t;
                        t = ux; ux = uy; uy = -t;
                    end
                end
                for (int i = 0; i < hfvr_pkg::CORDIC_STAGES && i < 63; i++)
                begin
                    da = ya >>> i;
                    db = yb >>> i;
                    dx = ux >>> i;
                    dy = uy >>> i;
                    if (yb >= 0)
                    begin
                        ya += db; yb -= da;
                        ux -= dy; uy += dx;
                    end
                    else
                    begin
                        ya -= db; yb += da;
                        ux += dy; uy -= dx;
                    end
                end
                rx = (ux * INV_GAIN_Q30 + ROUND_HALF) >>> (GAIN_SHIFT + VEL_GUARD);
                ry = (uy * INV_GAIN_Q30 + ROUND_HALF) >>> (GAIN_SHIFT + VEL_GUARD);
            end
            r.world_vx     = clamp_q(rx);
            r.world_vy     = clamp_q(ry);
            r.world_vz     = vz;
            r.yaw_rate_out = yr;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mismatches    = 0;
            pending       = 0;
            checked       = 0;
            zero_attitude = 0;
            saturated     = 0;
            expected_world_q.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                want = rotate_to_world(cmd.quat_w, cmd.quat_x, cmd.quat_y, cmd.quat_z,
                                       cmd.heading_vx, cmd.heading_vy,
                                       cmd.heading_vz, cmd.yaw_rate_in);
                expected_world_q.insert(expected_world_q.size(), want);
                if (want.bad_attitude)
                begin
                    zero_attitude++;
                end
                if (want.world_vx == hfvr_pkg::Q_MAX || want.world_vx == hfvr_pkg::Q_MIN
                    || want.world_vy == hfvr_pkg::Q_MAX || want.world_vy == hfvr_pkg::Q_MIN)
                begin
                    saturated++;
                end
            end
            if (vel.valid && vel.ready)
            begin
                got.bad_attitude = vel.bad_attitude;
                got.world_vx     = vel.world_vx;
                got.world_vy     = vel.world_vy;
                got.world_vz     = vel.world_vz;
                got.yaw_rate_out = vel.yaw_rate_out;
                if (expected_world_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: result beat with nothing expected:");
                        $display("       got bad=%0b vx=%0d vy=%0d vz=%0d yr=%0d",
                                 got.bad_attitude, got.world_vx, got.world_vy,
                                 got.world_vz, got.yaw_rate_out);
                    end
                end
                else
                begin
                    want = expected_world_q.pop_front();
                    checked++;
                    if (got.bad_attitude !== want.bad_attitude
                        || got.world_vx !== want.world_vx
                        || got.world_vy !== want.world_vy
                        || got.world_vz !== want.world_vz
                        || got.yaw_rate_out !== want.yaw_rate_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR: result %0d expected bad=%0b vx=%0d vy=%0d vz=%0d yr=%0d",
                                     checked, want.bad_attitude, want.world_vx,
                                     want.world_vy, want.world_vz, want.yaw_rate_out);
                            $display("       got bad=%0b vx=%0d vy=%0d vz=%0d yr=%0d",
                                     got.bad_attitude, got.world_vx, got.world_vy,
                                     got.world_vz, got.yaw_rate_out);
                        end
                    end
                end
            end
            pending = expected_world_q.size();
        end
    end

endmodule

>>> dv/testbench.sv
// ============================================================================
// testbench
// Drives attitude and heading-velocity commands into the rotation block,
// directed corner cases first and then random phases under varied idling
// and back-pressure; the checker beside the block predicts and compares.
// ============================================================================
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 150;

    typedef struct packed {
        logic signed [hfvr_pkg::Q_W-1:0] w;
        logic signed [hfvr_pkg::Q_W-1:0] x;
        logic signed [hfvr_pkg::Q_W-1:0] y;
        logic signed [hfvr_pkg::Q_W-1:0] z;
        logic signed [hfvr_pkg::Q_W-1:0] vx;
        logic signed [hfvr_pkg::Q_W-1:0] vy;
        logic signed [hfvr_pkg::Q_W-1:0] vz;
        logic signed [hfvr_pkg::Q_W-1:0] yr;
    } heading_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    int  idle_pct  = 0;
    int  stall_pct = 0;
    bit  hold_req  = 1'b0;
    bit  hold_ack  = 1'b0;
    int  n_sent    = 0;
    int  cycle_count = 0;

    int  mismatches;
    int  pending;
    int  checked;
    int  zero_attitude;
    int  saturated;

    hfvr_in_if  cmd_if();
    hfvr_out_if vel_if();

    heading_frame_velocity_rotate_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .vel   (vel_if)
    );

    world_velocity_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_if),
        .vel           (vel_if),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked),
        .zero_attitude (zero_attitude),
        .saturated     (saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus
    // side toggles hold_req.
    initial
    begin
        vel_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                vel_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else
            begin
                vel_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic signed [hfvr_pkg::Q_W-1:0] pick_corner();
        logic signed [hfvr_pkg::Q_W-1:0] v;
        case ($urandom_range(7))
            0:       v = 16'sh8000;
            1:       v = 16'sh8001;
            2:       v = 16'sh7FFF;
            3:       v = -16'sd1;
            4:       v = 16'sd1;
            5:       v = 16'sd0;
            6:       v = 16'sd16384;
            default: v = -16'sd16384;
        endcase
        return v;
    endfunction

    function automatic logic signed [hfvr_pkg::Q_W-1:0] pick_span(input int span);
        return hfvr_pkg::Q_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic heading_cmd_t random_cmd();
        heading_cmd_t c;
        int           kind;
        int           span;
        kind = $urandom_range(99);
        c.w  = hfvr_pkg::Q_W'($urandom);
        c.x  = hfvr_pkg::Q_W'($urandom);
        c.y  = hfvr_pkg::Q_W'($urandom);
        c.z  = hfvr_pkg::Q_W'($urandom);
        c.vx = hfvr_pkg::Q_W'($urandom);
        c.vy = hfvr_pkg::Q_W'($urandom);
        c.vz = hfvr_pkg::Q_W'($urandom);
        c.yr = hfvr_pkg::Q_W'($urandom);
        if (kind < 4)
        begin
            c.w = '0; c.x = '0; c.y = '0; c.z = '0;
        end
        else if (kind < 12)
        begin
            // Pure roll/pitch about x: the yaw is exactly zero.
            c.y = '0; c.z = '0;
        end
        else if (kind < 18)
        begin
            // Yaw vector on the negative x axis.
            c.w = '0; c.x = '0;
            if ($urandom_range(1))
            begin
                c.y = '0;
            end
        end
        else if (kind < 30)
        begin
            span = 1 << $urandom_range(8);
            c.w = pick_span(span);
            c.x = pick_span(span);
            c.y = pick_span(span);
            c.z = pick_span(span);
        end
        else if (kind < 40)
        begin
            c.w = pick_corner();
            c.x = pick_corner();
            c.y = pick_corner();
            c.z = pick_corner();
        end
        if ($urandom_range(9) == 0)
        begin
            c.vx = pick_corner();
            c.vy = pick_corner();
            c.vz = pick_corner();
            c.yr = pick_corner();
        end
        return c;
    endfunction

    function automatic heading_cmd_t mk(input int w, input int x, input int y, input int z,
                                        input int vx, input int vy, input int vz,
                                        input int yr);
        heading_cmd_t c;
        c.w  = hfvr_pkg::Q_W'(w);
        c.x  = hfvr_pkg::Q_W'(x);
        c.y  = hfvr_pkg::Q_W'(y);
        c.z  = hfvr_pkg::Q_W'(z);
        c.vx = hfvr_pkg::Q_W'(vx);
        c.vy = hfvr_pkg::Q_W'(vy);
        c.vz = hfvr_pkg::Q_W'(vz);
        c.yr = hfvr_pkg::Q_W'(yr);
        return c;
    endfunction

    task automatic send_cmd(input heading_cmd_t c);
        cmd_if.valid       <= 1'b1;
        cmd_if.quat_w      <= c.w;
        cmd_if.quat_x      <= c.x;
        cmd_if.quat_y      <= c.y;
        cmd_if.quat_z      <= c.z;
        cmd_if.heading_vx  <= c.vx;
        cmd_if.heading_vy  <= c.vy;
        cmd_if.heading_vz  <= c.vz;
        cmd_if.yaw_rate_in <= c.yr;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        n_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Stop offering beats until every predicted result has come back.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) send_cmd(random_cmd());
        drain();
    endtask

    initial
    begin
        heading_cmd_t directed[$];
        rst_n              <= 1'b0;
        cmd_if.valid       <= 1'b0;
        cmd_if.quat_w      <= '0;
        cmd_if.quat_x      <= '0;
        cmd_if.quat_y      <= '0;
        cmd_if.quat_z      <= '0;
        cmd_if.heading_vx  <= '0;
        cmd_if.heading_vy  <= '0;
        cmd_if.heading_vz  <= '0;
        cmd_if.yaw_rate_in <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Zero quaternion, identity, quarter turns in every quadrant,
        // saturation of the rotated pair and single-LSB attitudes.
        directed = {
            mk(0, 0, 0, 0, 32767, -32768, -32768, 32767),
            mk(0, 0, 0, 0, 0, 0, 0, 0),
            mk(16384, 0, 0, 0, 32767, -32768, 1234, -1),
            mk(-32768, 0, 0, 0, -32768, 32767, 0, 0),
            mk(0, 16384, 0, 0, 4096, -4096, 0, 100),
            mk(11585, 0, 0, 11585, 4096, 0, 0, 0),
            mk(11585, 0, 0, -11585, 4096, 2048, 0, 0),
            mk(0, 0, 0, 16384, 4096, 2048, -7, 7),
            mk(0, 0, 16384, 0, -4096, 2048, 0, 0),
            mk(6270, 0, 0, 15137, 8192, -8192, 0, 0),
            mk(6270, 0, 0, -15137, 8192, -8192, 0, 0),
            mk(0, 11585, 11585, 0, 1, -1, 0, 0),
            mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
            mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768),
            mk(15137, 0, 0, 6270, 32767, 32767, 0, 0),
            mk(15137, 0, 0, 6270, -32768, -32768, 0, 0),
            mk(15137, 0, 0, -6270, 32767, -32768, 0, 0),
            mk(1, 0, 0, 0, 5, -5, 0, 0),
            mk(1, 0, 0, 1, 32767, 0, 0, 0),
            mk(1, 0, 0, -1, 0, 32767, 0, 0),
            mk(0, 1, -1, 0, -32768, 32767, 0, 0),
            mk(0, 0, 1, 1, 12345, -12345, 0, 0),
            mk(-1, -1, -1, -1, -1, -1, -1, -1)
        };
        idle_pct  = 0;
        stall_pct = 0;
        foreach (directed[i]) send_cmd(directed[i]);
        drain();

        run_phase(300, 0, 0);
        run_phase(300, 51, 0);
        run_phase(300, 0, 51);
        run_phase(300, 37, 37);

        // Hold the result side off long enough that the pipeline fills and
        // the command side has to wait.
        idle_pct  = 0;
        stall_pct = 0;
        hold_req <= ~hold_req;
        repeat (100) send_cmd(random_cmd());
        drain();

        run_phase(150, $urandom_range(60), $urandom_range(60));

        repeat (hfvr_pkg::PIPE_DEPTH + 10) @(posedge clk);

        $display("Sent %0d commands; %0d results checked, %0d with a zero attitude,",
                 n_sent, checked, zero_attitude);
        $display("%0d with a saturated rotated component; %0d mismatches.",
                 saturated, mismatches);
        if (mismatches == 0 && pending == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
